// ----- rtl/yaw_pitch_camera_basis_defines.svh -----
// ----------------------------------------------------------------------------
// yaw pitch camera basis assertion macros
// concurrent checks on the clock and reset of the including module
// ----------------------------------------------------------------------------
`ifndef YAW_PITCH_CAMERA_BASIS_DEFINES_SVH
`define YAW_PITCH_CAMERA_BASIS_DEFINES_SVH
`ifndef SYNTH
`define YPCB_ASSERT_NOW(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("check failed");
`define YPCB_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define YPCB_ASSERT_NOW(name, ck, rn, ante, cons)
`define YPCB_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/ypcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ypcb_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
package ypcb_pkg;

    localparam int ANGLE_FRAC_BITS  = 16;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int POSITION_WIDTH   = 24;
    localparam int TRIG_ITERATIONS  = 16;

    localparam int VEC_W    = VECTOR_FRAC_BITS + 2;
    localparam int TARGET_W = POSITION_WIDTH + VECTOR_FRAC_BITS - 7;
    localparam int YAW_W    = 19;
    localparam int PITCH_W  = 18;
    localparam int DELTA_W  = 21;
    localparam int CW       = 33;
    localparam int STAGE_W  = 5;

    localparam longint PI_Q48      = 64'd884279719003555;
    localparam longint TENTH_Q48   = 64'd28147497671066;
    localparam int     ASH         = 48 - ANGLE_FRAC_BITS;
    localparam longint HALF_ASH    = longint'(1) << (ASH - 1);
    localparam longint TWO_PI_ANG  = (2 * PI_Q48 + HALF_ASH) >>> ASH;
    localparam longint YAW_RESET   = (PI_Q48 + PI_Q48 / 2 + HALF_ASH) >>> ASH;
    localparam longint PITCH_LIMIT = (PI_Q48 / 2 - TENTH_Q48 + HALF_ASH) >>> ASH;
    localparam longint PI30        = (PI_Q48 + (longint'(1) << 17)) >>> 18;
    localparam longint HALF30      = (PI_Q48 / 2 + (longint'(1) << 17)) >>> 18;
    localparam longint GAIN30      = 64'h26DD3B6A;
    localparam longint DEG2RAD_Q32 = 64'd74961321;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t yaw;
        cordic_lane_t pitch;
    } cordic_pair_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic signed [CW-1:0] r;
        case (idx)
            5'd0:    r = 33'sh03243F6A8;
            5'd1:    r = 33'sh01DAC6705;
            5'd2:    r = 33'sh00FADBAFC;
            5'd3:    r = 33'sh007F56EA6;
            5'd4:    r = 33'sh003FEAB76;
            5'd5:    r = 33'sh001FFD55B;
            5'd6:    r = 33'sh000FFFAAA;
            5'd7:    r = 33'sh0007FFF55;
            5'd8:    r = 33'sh0003FFFEA;
            5'd9:    r = 33'sh0001FFFFD;
            5'd10:   r = 33'sh0000FFFFF;
            5'd11:   r = 33'sh00007FFFF;
            5'd12:   r = 33'sh00003FFFF;
            5'd13:   r = 33'sh00001FFFF;
            5'd14:   r = 33'sh00000FFFF;
            5'd15:   r = 33'sh000007FFF;
            5'd16:   r = 33'sh000003FFF;
            5'd17:   r = 33'sh000001FFF;
            5'd18:   r = 33'sh000000FFF;
            5'd19:   r = 33'sh0000007FF;
            5'd20:   r = 33'sh0000003FF;
            5'd21:   r = 33'sh0000001FF;
            5'd22:   r = 33'sh0000000FF;
            5'd23:   r = 33'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/yaw_pitch_camera_basis.sv -----
// ----------------------------------------------------------------------------
// yaw_pitch_camera_basis
// first-person camera angles, eye position and look/right/up/target vectors
// ----------------------------------------------------------------------------
// One request at a time: after a request is taken the block raises its
// result after degree conversion, angle and position update, range
// reduction, 16 cordic cells in a row, products and rounding, and takes the
// next request in the cycle after the result has been taken. The chain of
// cordic cells has one cell per iteration.
module yaw_pitch_camera_basis (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // yaw_delta, pitch_delta, move_x, move_y, move_z
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // look_x, look_y, look_z, right_x, right_y, right_z, up_x, up_y, up_z,
    // target_x, target_y, target_z
    output logic [223:0]  m_axis_tdata
);

    localparam int N  = ypcb_pkg::TRIG_ITERATIONS;
    localparam int VW = ypcb_pkg::VEC_W;
    localparam int TW = ypcb_pkg::TARGET_W;
    localparam int PW = ypcb_pkg::POSITION_WIDTH;
    localparam int CW = ypcb_pkg::CW;
    localparam int PRW = 2 * CW;

    logic busy_reg;
    logic in_acc;
    logic out_acc;

    // conversion stage
    logic                     mul_valid_reg;
    logic signed [44:0]       yaw_prod_reg;
    logic signed [44:0]       pitch_prod_reg;
    logic signed [PW-1:0]     move_reg [3];

    // state
    logic                     upd_valid_reg;
    logic [ypcb_pkg::YAW_W-1:0]          yaw_reg;
    logic signed [ypcb_pkg::PITCH_W-1:0] pitch_reg;
    logic signed [PW-1:0]     eye_reg [3];
    logic [ypcb_pkg::YAW_W-1:0]          yaw_next;
    logic signed [ypcb_pkg::PITCH_W-1:0] pitch_next;
    logic signed [PW-1:0]     eye_next [3];

    // reduction stage
    logic                     red_valid_reg;
    ypcb_pkg::cordic_pair_t   red_reg;

    logic                     cell_valid [N+1];
    ypcb_pkg::cordic_pair_t   cell_data  [N+1];

    // product stage
    logic                     prod_valid_reg;
    logic signed [PRW-1:0]    cpcy_reg;
    logic signed [PRW-1:0]    cpsy_reg;
    logic signed [PRW-1:0]    spcy_reg;
    logic signed [PRW-1:0]    spsy_reg;
    logic signed [CW-1:0]     sy_reg;
    logic signed [CW-1:0]     cy_reg;
    logic signed [CW-1:0]     sp_reg;
    logic signed [CW-1:0]     cp_reg;
    logic signed [PW-1:0]     eye_snap_reg [3];
    logic signed [CW-1:0]     sy_f;
    logic signed [CW-1:0]     cy_f;
    logic signed [CW-1:0]     sp_f;
    logic signed [CW-1:0]     cp_f;

    // output register
    logic                     out_valid_reg;
    logic signed [VW-1:0]     look_reg [3];
    logic signed [VW-1:0]     right_x_reg;
    logic signed [VW-1:0]     right_z_reg;
    logic signed [VW-1:0]     up_reg [3];
    logic signed [TW-1:0]     target_reg [3];
    logic signed [VW-1:0]     look_next [3];

    function automatic logic signed [VW-1:0] clamp_vec(input logic signed [PRW-1:0] t);
        logic signed [PRW-1:0] one;
        logic signed [PRW-1:0] r;
        one = PRW'(longint'(1) << ypcb_pkg::VECTOR_FRAC_BITS);
        r = t;
        if (t > one)
            r = one;
        if (t < -one)
            r = -one;
        return r[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] vec_prod(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] t;
        t = (p + (PRW'(1) <<< (59 - ypcb_pkg::VECTOR_FRAC_BITS)))
            >>> (60 - ypcb_pkg::VECTOR_FRAC_BITS);
        return clamp_vec(t);
    endfunction

    function automatic logic signed [VW-1:0] vec_one(input logic signed [CW-1:0] a);
        logic signed [PRW-1:0] t;
        t = (PRW'(a) + (PRW'(1) <<< (29 - ypcb_pkg::VECTOR_FRAC_BITS)))
            >>> (30 - ypcb_pkg::VECTOR_FRAC_BITS);
        return clamp_vec(t);
    endfunction

    function automatic ypcb_pkg::cordic_lane_t reduce(input logic signed [34:0] a);
        ypcb_pkg::cordic_lane_t r;
        logic signed [34:0] pi30;
        logic signed [34:0] half30;
        logic signed [34:0] v;
        pi30   = 35'(ypcb_pkg::PI30);
        half30 = 35'(ypcb_pkg::HALF30);
        v = a;
        r.flip = 1'b0;
        if (a > pi30 + half30)
            v = a - (pi30 <<< 1);
        else if (a > half30)
        begin
            v = a - pi30;
            r.flip = 1'b1;
        end
        else if (a < -half30)
        begin
            v = a + pi30;
            r.flip = 1'b1;
        end
        r.x = CW'(ypcb_pkg::GAIN30);
        r.y = '0;
        r.z = v[CW-1:0];
        return r;
    endfunction

    function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [PW:0] s;
        s = {a[PW-1], a} + {b[PW-1], b};
        if (s[PW] != s[PW-1])
            return s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        return s[PW-1:0];
    endfunction

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        logic signed [ypcb_pkg::DELTA_W-1:0] dy;
        logic signed [ypcb_pkg::DELTA_W-1:0] dp;
        logic signed [ypcb_pkg::DELTA_W-1:0] ys;
        logic signed [ypcb_pkg::DELTA_W-1:0] ps;
        logic signed [ypcb_pkg::DELTA_W-1:0] two_pi;
        logic signed [ypcb_pkg::DELTA_W-1:0] lim;
        logic signed [44:0] t;
        two_pi = ypcb_pkg::DELTA_W'(ypcb_pkg::TWO_PI_ANG);
        lim    = ypcb_pkg::DELTA_W'(ypcb_pkg::PITCH_LIMIT);
        t  = (yaw_prod_reg + (45'sd1 <<< 23)) >>> 24;
        dy = t[ypcb_pkg::DELTA_W-1:0];
        t  = (pitch_prod_reg + (45'sd1 <<< 23)) >>> 24;
        dp = t[ypcb_pkg::DELTA_W-1:0];
        ys = $signed({2'b00, yaw_reg}) + dy;
        if (ys < 0)
            ys = ys + two_pi;
        else if (ys >= two_pi)
            ys = ys - two_pi;
        yaw_next = ys[ypcb_pkg::YAW_W-1:0];
        ps = ypcb_pkg::DELTA_W'(pitch_reg) + dp;
        if (ps > lim)
            ps = lim;
        if (ps < -lim)
            ps = -lim;
        pitch_next = ps[ypcb_pkg::PITCH_W-1:0];
        for (int k = 0; k < 3; k++)
            eye_next[k] = sat_add(eye_reg[k], move_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            mul_valid_reg  <= 1'b0;
            upd_valid_reg  <= 1'b0;
            red_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            yaw_reg        <= ypcb_pkg::YAW_W'(ypcb_pkg::YAW_RESET);
            pitch_reg      <= '0;
            for (int k = 0; k < 3; k++)
                eye_reg[k] <= '0;
        end
        else
        begin
            mul_valid_reg  <= in_acc;
            upd_valid_reg  <= mul_valid_reg;
            red_valid_reg  <= upd_valid_reg;
            prod_valid_reg <= cell_valid[N];
            if (in_acc)
                busy_reg <= 1'b1;
            else if (out_acc)
                busy_reg <= 1'b0;
            if (prod_valid_reg)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
            if (mul_valid_reg)
            begin
                yaw_reg   <= yaw_next;
                pitch_reg <= pitch_next;
                for (int k = 0; k < 3; k++)
                    eye_reg[k] <= eye_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            yaw_prod_reg   <= 45'($signed(s_axis_tdata[16:0])) * 45'(ypcb_pkg::DEG2RAD_Q32);
            pitch_prod_reg <= 45'($signed(s_axis_tdata[33:17])) * 45'(ypcb_pkg::DEG2RAD_Q32);
            move_reg[0]    <= s_axis_tdata[57:34];
            move_reg[1]    <= s_axis_tdata[81:58];
            move_reg[2]    <= s_axis_tdata[105:82];
        end
        red_reg.yaw   <= reduce($signed({16'd0, yaw_reg}) <<< (30 - ypcb_pkg::ANGLE_FRAC_BITS));
        red_reg.pitch <= reduce(35'(pitch_reg) <<< (30 - ypcb_pkg::ANGLE_FRAC_BITS));
    end

    assign cell_valid[0] = red_valid_reg;
    assign cell_data[0]  = red_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ypcb_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (ypcb_pkg::STAGE_W'(g)),
            .in_valid  (cell_valid[g]),
            .in_data   (cell_data[g]),
            .out_valid (cell_valid[g+1]),
            .out_data  (cell_data[g+1])
        );
    end

    assign sy_f = cell_data[N].yaw.flip   ? -cell_data[N].yaw.y   : cell_data[N].yaw.y;
    assign cy_f = cell_data[N].yaw.flip   ? -cell_data[N].yaw.x   : cell_data[N].yaw.x;
    assign sp_f = cell_data[N].pitch.flip ? -cell_data[N].pitch.y : cell_data[N].pitch.y;
    assign cp_f = cell_data[N].pitch.flip ? -cell_data[N].pitch.x : cell_data[N].pitch.x;

    always_ff @(posedge clk)
    begin
        cpcy_reg <= PRW'(cp_f) * PRW'(cy_f);
        cpsy_reg <= PRW'(cp_f) * PRW'(sy_f);
        spcy_reg <= PRW'(sp_f) * PRW'(cy_f);
        spsy_reg <= PRW'(sp_f) * PRW'(sy_f);
        sy_reg   <= sy_f;
        cy_reg   <= cy_f;
        sp_reg   <= sp_f;
        cp_reg   <= cp_f;
        for (int k = 0; k < 3; k++)
            eye_snap_reg[k] <= eye_reg[k];
    end

    always_comb
    begin
        look_next[0] = vec_prod(cpcy_reg);
        look_next[1] = vec_one(sp_reg);
        look_next[2] = vec_prod(cpsy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                look_reg[k]   <= look_next[k];
                target_reg[k] <= (TW'(eye_snap_reg[k]) <<< (ypcb_pkg::VECTOR_FRAC_BITS - 8))
                                 + TW'(look_next[k]);
            end
            right_x_reg <= vec_one(-sy_reg);
            right_z_reg <= vec_one(cy_reg);
            up_reg[0]   <= vec_prod(-spcy_reg);
            up_reg[1]   <= vec_one(cp_reg);
            up_reg[2]   <= vec_prod(-spsy_reg);
        end
    end

    assign m_axis_tdata = {2'b00, target_reg[2], target_reg[1], target_reg[0],
                           up_reg[2], up_reg[1], up_reg[0], right_z_reg, 1'b0,
                           right_x_reg, look_reg[2], look_reg[1], look_reg[0]};

`include "yaw_pitch_camera_basis_defines.svh"

    `YPCB_ASSERT_NOW(a_out_needs_busy, clk, rst_n, m_axis_tvalid, busy_reg)
    `YPCB_ASSERT_NEXT(a_one_request, clk, rst_n, in_acc, !s_axis_tready)
    `YPCB_ASSERT_NOW(a_one_in_flight, clk, rst_n, 1'b1,
        $onehot0({mul_valid_reg, upd_valid_reg, red_valid_reg, cell_valid[N], prod_valid_reg}))
    `YPCB_ASSERT_NOW(a_pitch_limit, clk, rst_n, 1'b1,
        (pitch_reg <= $signed(ypcb_pkg::PITCH_W'(ypcb_pkg::PITCH_LIMIT))) &&
        (pitch_reg >= -$signed(ypcb_pkg::PITCH_W'(ypcb_pkg::PITCH_LIMIT))))

endmodule

// ----- rtl/ypcb_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// ypcb_cordic_cell
// one registered cordic rotation step for the yaw and pitch lanes
// ----------------------------------------------------------------------------
module ypcb_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ypcb_pkg::STAGE_W-1:0]  stage,
    input  logic                          in_valid,
    input  ypcb_pkg::cordic_pair_t        in_data,
    output logic                          out_valid,
    output ypcb_pkg::cordic_pair_t        out_data
);

    logic                   valid_reg;
    ypcb_pkg::cordic_pair_t data_reg;
    ypcb_pkg::cordic_pair_t data_next;

    function automatic ypcb_pkg::cordic_lane_t rotate(input ypcb_pkg::cordic_lane_t l,
                                                      input logic [ypcb_pkg::STAGE_W-1:0] s);
        ypcb_pkg::cordic_lane_t r;
        logic signed [ypcb_pkg::CW-1:0] xs;
        logic signed [ypcb_pkg::CW-1:0] ys;
        logic signed [ypcb_pkg::CW-1:0] at;
        xs = l.x >>> s;
        ys = l.y >>> s;
        at = ypcb_pkg::atan_q30(s);
        r.flip = l.flip;
        if (l.z >= 0)
        begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - at;
        end
        else
        begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + at;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next.yaw   = rotate(in_data.yaw, stage);
        data_next.pitch = rotate(in_data.pitch, stage);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
